FILE: src/tt_pkg.sv
package tt_pkg;

  // Default grid geometry
  localparam int DEF_GRID_COLUMNS = 52;
  localparam int DEF_GRID_ROWS    = 16;

  // Command codes
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Control bytes and the printable range
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] PRINT_LO   = 8'h20;
  localparam logic [7:0] PRINT_HI   = 8'h7E;
  localparam int         TAB_STOP   = 8;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCRUB_ADDR,
    ST_SCRUB_LOAD,
    ST_SCRUB,
    ST_ACC_ADDR,
    ST_ACC,
    ST_READ_WAIT,
    ST_DONE
  } tt_state_t;

endpackage

FILE: src/tt_addr_unit.sv
module tt_addr_unit #(
  parameter int GRID_COLUMNS = tt_pkg::DEF_GRID_COLUMNS,
  parameter int GRID_ROWS    = tt_pkg::DEF_GRID_ROWS,
  parameter int RW           = $clog2(GRID_ROWS),
  parameter int CW           = $clog2(GRID_COLUMNS + 1),
  parameter int AW           = $clog2(GRID_ROWS * GRID_COLUMNS)
) (
  input  logic          clk,
  input  logic [RW-1:0] offset,
  input  logic [RW-1:0] row,
  input  logic [CW-1:0] col,
  output logic [AW-1:0] addr
);

  logic [RW:0]   row_sum;
  logic [RW:0]   phys_row;
  logic [31:0]   lin_addr;

  // Rotate the logical row by the scroll offset, then linearize
  always_comb begin
    row_sum = {1'b0, offset} + {1'b0, row};
    if (row_sum >= (RW+1)'(GRID_ROWS)) begin
      phys_row = row_sum - (RW+1)'(GRID_ROWS);
    end else begin
      phys_row = row_sum;
    end
    lin_addr = 32'(phys_row) * 32'(GRID_COLUMNS) + 32'(col);
  end

  // Register the cell address
  always_ff @(posedge clk) begin
    addr <= lin_addr[AW-1:0];
  end

endmodule

FILE: src/text_terminal_grid.sv
// Character-cell text grid for a plain terminal (no escape sequences). A put
// item (cmd 0) feeds one byte: LF, CR, BS and TAB move the cursor, printable
// bytes 0x20..0x7E are stored, everything else is ignored. A read item (cmd 1)
// returns one stored cell. Every item yields exactly one result carrying the
// cursor after the item and a flag for a scroll. Items are handled one at a
// time by a small sequencer around one address unit (row rotate plus
// row*columns+col) and a single-port cell memory. A put that stores or clears
// a cell goes from decode through the address and access states to the result,
// a put that only moves the cursor goes from decode straight to the result, and
// a read inside the grid adds a wait for the registered read. A scroll rotates
// the row offset and then clears the new bottom row one cell per cycle. After
// reset the block clears the whole memory, one cell per cycle, with in_stall high.
module text_terminal_grid #(
  parameter int GRID_COLUMNS = tt_pkg::DEF_GRID_COLUMNS,
  parameter int GRID_ROWS    = tt_pkg::DEF_GRID_ROWS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       cmd,
  input  logic [7:0] data_byte,
  input  logic [3:0] read_row,
  input  logic [5:0] read_col,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] cell_char,
  output logic [5:0] cursor_col,
  output logic [3:0] cursor_row,
  output logic       scrolled
);

  import tt_pkg::*;

  localparam int CELLS = GRID_ROWS * GRID_COLUMNS;
  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CW    = $clog2(GRID_COLUMNS + 1);
  localparam int AW    = $clog2(CELLS);

  tt_state_t     state;
  tt_state_t     state_next;

  // Cursor and scroll offset
  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_line;
  logic [RW-1:0] offset;

  // Held item
  logic          it_cmd;
  logic [7:0]    it_byte;
  logic [3:0]    it_row;
  logic [5:0]    it_col;

  // Work registers
  logic [RW-1:0] tgt_row;
  logic [CW-1:0] tgt_col;
  logic          do_write;
  logic          do_read;
  logic [6:0]    wval;
  logic          scroll_q;
  logic [6:0]    cell_q;
  logic [AW-1:0] ptr;
  logic [CW-1:0] cnt;

  // Address unit
  logic [RW-1:0] au_row;
  logic [CW-1:0] au_col;
  logic [AW-1:0] au_addr;

  // Memory port
  logic [6:0]    mem [CELLS];
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [6:0]    mem_wdata;
  logic [6:0]    rd_data;

  // Decode results
  logic [CW-1:0] dec_col;
  logic [RW-1:0] dec_line;
  logic [CW-1:0] dec_wcol;
  logic          dec_write;
  logic [6:0]    dec_wval;
  logic          dec_scroll;
  logic          dec_adv;
  logic          dec_rd_ok;
  logic [CW:0]   tab_col;
  logic [31:0]   row_ext;
  logic [31:0]   col_ext;
  logic [31:0]   out_col_ext;
  logic [31:0]   out_row_ext;

  tt_addr_unit #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS),
    .RW           (RW),
    .CW           (CW),
    .AW           (AW)
  ) u_addr (
    .clk    (clk),
    .offset (offset),
    .row    (au_row),
    .col    (au_col),
    .addr   (au_addr)
  );

  // Steer the address unit: bottom row start while scrubbing, else the target cell
  always_comb begin
    if (state == ST_SCRUB_ADDR) begin
      au_row = RW'(GRID_ROWS - 1);
      au_col = '0;
    end else begin
      au_row = tgt_row;
      au_col = tgt_col;
    end
  end

  // Decode the held item against the cursor
  always_comb begin
    dec_col    = cur_col;
    dec_line   = cur_line;
    dec_wcol   = cur_col;
    dec_write  = 1'b0;
    dec_wval   = it_byte[6:0];
    dec_scroll = 1'b0;
    dec_adv    = 1'b0;
    tab_col    = ({1'b0, cur_col} + (CW+1)'(TAB_STOP)) & ~(CW+1)'(TAB_STOP - 1);
    row_ext    = 32'(it_row);
    col_ext    = 32'(it_col);
    dec_rd_ok  = (row_ext < 32'(GRID_ROWS)) && (col_ext < 32'(GRID_COLUMNS));
    if (it_cmd == CMD_PUT) begin
      case (it_byte)
        CHAR_LF: begin
          dec_adv = 1'b1;
          dec_col = '0;
        end
        CHAR_CR: begin
          dec_col = '0;
        end
        CHAR_BS: begin
          if (cur_col != '0) begin
            dec_col   = cur_col - CW'(1);
            dec_wcol  = cur_col - CW'(1);
            dec_wval  = '0;
            dec_write = 1'b1;
          end
        end
        CHAR_TAB: begin
          if (tab_col >= (CW+1)'(GRID_COLUMNS)) begin
            dec_adv = 1'b1;
            dec_col = '0;
          end else begin
            dec_col = tab_col[CW-1:0];
          end
        end
        default: begin
          if (it_byte >= PRINT_LO && it_byte <= PRINT_HI) begin
            if (cur_col == CW'(GRID_COLUMNS)) begin
              dec_adv  = 1'b1;
              dec_wcol = '0;
            end
            dec_write = 1'b1;
            dec_col   = dec_wcol + CW'(1);
          end
        end
      endcase
      // Advance the line, scrolling at the bottom
      if (dec_adv) begin
        if (cur_line == RW'(GRID_ROWS - 1)) begin
          dec_scroll = 1'b1;
        end else begin
          dec_line = cur_line + RW'(1);
        end
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (ptr == AW'(CELLS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (it_cmd == CMD_PUT) begin
          if (dec_scroll) begin
            state_next = ST_SCRUB_ADDR;
          end else if (dec_write) begin
            state_next = ST_ACC_ADDR;
          end else begin
            state_next = ST_DONE;
          end
        end else if (dec_rd_ok) begin
          state_next = ST_ACC_ADDR;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SCRUB_ADDR: state_next = ST_SCRUB_LOAD;
      ST_SCRUB_LOAD: state_next = ST_SCRUB;
      ST_SCRUB: begin
        if (cnt == CW'(GRID_COLUMNS - 1)) begin
          state_next = do_write ? ST_ACC_ADDR : ST_DONE;
        end
      end
      ST_ACC_ADDR: state_next = ST_ACC;
      ST_ACC: begin
        state_next = do_read ? ST_READ_WAIT : ST_DONE;
      end
      ST_READ_WAIT: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake and memory port controls
  always_comb begin
    in_stall  = (state != ST_IDLE);
    out_valid = (state == ST_DONE);
    mem_we    = 1'b0;
    mem_addr  = au_addr;
    mem_wdata = '0;
    case (state)
      ST_CLEAR, ST_SCRUB: begin
        mem_we   = 1'b1;
        mem_addr = ptr;
      end
      ST_ACC: begin
        mem_we    = do_write;
        mem_wdata = wval;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Cell memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data <= mem[mem_addr];
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Control registers: cursor, offset, sweep pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col  <= '0;
      cur_line <= '0;
      offset   <= '0;
      ptr      <= '0;
      cnt      <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          ptr <= ptr + AW'(1);
        end
        ST_DECODE: begin
          cur_col  <= dec_col;
          cur_line <= dec_line;
          if (dec_scroll) begin
            if (offset == RW'(GRID_ROWS - 1)) begin
              offset <= '0;
            end else begin
              offset <= offset + RW'(1);
            end
          end
        end
        ST_SCRUB_LOAD: begin
          ptr <= au_addr;
          cnt <= '0;
        end
        ST_SCRUB: begin
          ptr <= ptr + AW'(1);
          cnt <= cnt + CW'(1);
        end
        default: begin
          cnt <= cnt;
        end
      endcase
    end
  end

  // Item and result registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      it_cmd  <= cmd;
      it_byte <= data_byte;
      it_row  <= read_row;
      it_col  <= read_col;
    end
    if (state == ST_DECODE) begin
      do_write <= (it_cmd == CMD_PUT) && dec_write;
      do_read  <= (it_cmd == CMD_READ);
      wval     <= dec_wval;
      scroll_q <= dec_scroll;
      cell_q   <= '0;
      if (it_cmd == CMD_PUT) begin
        tgt_row <= dec_line;
        tgt_col <= dec_wcol;
      end else begin
        tgt_row <= row_ext[RW-1:0];
        tgt_col <= col_ext[CW-1:0];
      end
    end
    if (state == ST_READ_WAIT) begin
      cell_q <= rd_data;
    end
  end

  // Result ports
  assign out_col_ext = 32'(cur_col);
  assign out_row_ext = 32'(cur_line);
  assign cell_char   = cell_q;
  assign cursor_col  = out_col_ext[5:0];
  assign cursor_row  = out_row_ext[3:0];
  assign scrolled    = scroll_q;

endmodule
